[hdl/cic_pkg.sv]
package cic_pkg;

  // accumulator width, every integrator and comb wraps modulo 2^ACC_WIDTH (32..64)
  localparam int unsigned ACC_WIDTH = 64;
  localparam int unsigned SAMPLE_WIDTH = 32;
  localparam int unsigned RATIO_WIDTH = 16;
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned VALUE_WIDTH = 64;
  localparam int unsigned NUM_STAGES = 3;

  localparam logic [RATIO_WIDTH-1:0] RATIO_RESET = RATIO_WIDTH'(32);

  typedef logic [ACC_WIDTH-1:0] acc_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [RATIO_WIDTH-1:0] ratio_t;

  // data handed from one cell to the next
  typedef struct packed {
    acc_t   data;
    logic   dec;
    count_t cnt;
  } link_t;

endpackage

[hdl/cic_ifs.sv]
interface cic_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [cic_pkg::SAMPLE_WIDTH-1:0]     sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface cic_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [cic_pkg::VALUE_WIDTH-1:0] filtered_value;
  logic [cic_pkg::COUNT_WIDTH-1:0]      output_count;

  modport source (output valid, output filtered_value, output output_count, input ready);
  modport sink (input valid, input filtered_value, input output_count, output ready);
endinterface

[hdl/cic_int_cell.sv]
module cic_int_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_vld,
  input  cic_pkg::link_t in_link,
  output logic           in_rdy,
  output logic           out_vld,
  output cic_pkg::link_t out_link,
  input  logic           out_rdy
);

  logic          vld_r;
  cic_pkg::acc_t acc_r;
  cic_pkg::acc_t acc_nxt;
  logic          dec_r;
  cic_pkg::count_t cnt_r;
  logic          take;

  // cell frees up when empty or when its request moves on
  assign in_rdy  = !vld_r || out_rdy;
  assign take    = in_vld && in_rdy;
  assign acc_nxt = acc_r + in_link.data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      acc_r <= '0;
    end else begin
      if (in_rdy) begin
        vld_r <= in_vld;
      end
      if (take) begin
        acc_r <= acc_nxt;
      end
    end
  end

  // side fields ride along with the request
  always_ff @(posedge clk) begin
    if (take) begin
      dec_r <= in_link.dec;
      cnt_r <= in_link.cnt;
    end
  end

  assign out_vld       = vld_r;
  assign out_link.data = acc_r;
  assign out_link.dec  = dec_r;
  assign out_link.cnt  = cnt_r;

endmodule

[hdl/cic_comb_cell.sv]
module cic_comb_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_vld,
  input  cic_pkg::link_t in_link,
  output logic           in_rdy,
  output logic           out_vld,
  output cic_pkg::link_t out_link,
  input  logic           out_rdy
);

  logic            vld_r;
  cic_pkg::acc_t   d0_r;
  cic_pkg::acc_t   d1_r;
  cic_pkg::acc_t   y_r;
  logic            dec_r;
  cic_pkg::count_t cnt_r;
  logic            take;

  assign in_rdy = !vld_r || out_rdy;
  assign take   = in_vld && in_rdy;

  // valid bit and the two-deep delay line (filter state, cleared on reset)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      d0_r  <= '0;
      d1_r  <= '0;
    end else begin
      if (in_rdy) begin
        vld_r <= in_vld;
      end
      if (take) begin
        d1_r <= d0_r;
        d0_r <= in_link.data;
      end
    end
  end

  // difference against the value two decimations back
  always_ff @(posedge clk) begin
    if (take) begin
      y_r   <= in_link.data - d1_r;
      dec_r <= in_link.dec;
      cnt_r <= in_link.cnt;
    end
  end

  assign out_vld       = vld_r;
  assign out_link.data = y_r;
  assign out_link.dec  = dec_r;
  assign out_link.cnt  = cnt_r;

endmodule

[hdl/cic_decimator_three_stage_core.sv]
// channel   dir  payload                                  handshake
// in_ch     in   sample[31:0]                             valid/ready
// out_ch    out  filtered_value[63:0] s, output_count[15:0] valid/ready
// cfg       in   cfg_wdata[15:0] decimation ratio         cfg_we, no wait
//
// one sample accepted per clock while in_ch.ready is high; the sample that
// completes a decimation is registered in three integrator then three comb cells
// each cell holds one request and is ready when empty or draining, so a
// stalled output only blocks input once every cell is full
// rst_n is synchronous: clears integrators, comb delays, counters, ratio to 32
module cic_decimator_three_stage_core (
  input  logic                               clk,
  input  logic                               rst_n,
  cic_in_if.sink                             in_ch,
  cic_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [cic_pkg::RATIO_WIDTH-1:0]    cfg_wdata
);

  localparam int unsigned NS = cic_pkg::NUM_STAGES;

  cic_pkg::ratio_t ratio_r;
  cic_pkg::ratio_t dec_cnt_r;
  cic_pkg::ratio_t dec_cnt_nxt;
  cic_pkg::count_t out_cnt_r;
  logic            dec_now;
  logic            in_take;
  logic            comb_take;

  cic_pkg::link_t  int_link [0:NS];
  logic            int_vld  [0:NS];
  logic            int_rdy  [0:NS];
  cic_pkg::link_t  comb_link [0:NS];
  logic            comb_vld  [0:NS];
  logic            comb_rdy  [0:NS];

  // ratio register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= cic_pkg::RATIO_RESET;
    end else if (cfg_we) begin
      ratio_r <= cfg_wdata;
    end
  end

  // decimation counter, decided as the sample enters
  assign in_take     = in_ch.valid && in_ch.ready;
  assign dec_cnt_nxt = dec_cnt_r + cic_pkg::RATIO_WIDTH'(1);
  assign dec_now     = (dec_cnt_nxt >= ratio_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_cnt_r <= '0;
    end else if (in_take) begin
      dec_cnt_r <= dec_now ? '0 : dec_cnt_nxt;
    end
  end

  // integrator chain input
  assign int_vld[0]       = in_ch.valid;
  assign int_link[0].data = cic_pkg::ACC_WIDTH'(in_ch.sample);
  assign int_link[0].dec  = dec_now;
  assign int_link[0].cnt  = '0;
  assign in_ch.ready      = int_rdy[0];

  for (genvar i = 0; i < NS; i++) begin : g_int
    cic_int_cell u_int (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (int_vld[i]),
      .in_link  (int_link[i]),
      .in_rdy   (int_rdy[i]),
      .out_vld  (int_vld[i+1]),
      .out_link (int_link[i+1]),
      .out_rdy  (int_rdy[i+1])
    );
  end

  // only decimation points enter the combs, the rest drop here
  assign comb_vld[0]       = int_vld[NS] && int_link[NS].dec;
  assign comb_link[0].data = int_link[NS].data;
  assign comb_link[0].dec  = int_link[NS].dec;
  assign comb_link[0].cnt  = out_cnt_r + cic_pkg::COUNT_WIDTH'(1);
  assign int_rdy[NS]       = !int_link[NS].dec || comb_rdy[0];
  assign comb_take         = comb_vld[0] && comb_rdy[0];

  // running output count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_cnt_r <= '0;
    end else if (comb_take) begin
      out_cnt_r <= comb_link[0].cnt;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_comb
    cic_comb_cell u_comb (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (comb_vld[i]),
      .in_link  (comb_link[i]),
      .in_rdy   (comb_rdy[i]),
      .out_vld  (comb_vld[i+1]),
      .out_link (comb_link[i+1]),
      .out_rdy  (comb_rdy[i+1])
    );
  end

  // result port, sign extended from the accumulator width
  assign out_ch.valid          = comb_vld[NS];
  assign out_ch.filtered_value = cic_pkg::VALUE_WIDTH'($signed(comb_link[NS].data));
  assign out_ch.output_count   = comb_link[NS].cnt;
  assign comb_rdy[NS]          = out_ch.ready;

`ifndef SYNTH
  // counter stays below a nonzero ratio after every accepted sample without a ratio write
  a_cnt_below_ratio: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(in_take) && !$past(cfg_we) && ratio_r != '0)
      |-> (dec_cnt_r < ratio_r))
    else $error("decimation counter not below ratio");

  // output count moves by one per request entering the combs, else holds
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(comb_take))
      |-> (out_cnt_r == $past(out_cnt_r) + cic_pkg::COUNT_WIDTH'(1)))
    else $error("output count did not advance");

  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(comb_take)) |-> $stable(out_cnt_r))
    else $error("output count changed without a result");

  // input backs up only when every cell is full and the output is stalled
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (int_vld[1] && int_vld[2] && int_vld[3] && int_link[NS].dec &&
                      comb_vld[1] && comb_vld[2] && comb_vld[3] && !out_ch.ready))
    else $error("input stalled with a free cell");
`endif

endmodule
